### design/mjs_pkg.sv
// Shared constants, operation codes and saturation helper for the minimum-jerk servo.
`default_nettype none
package mjs_pkg;

  localparam int DW     = 32;            // data width, signed Q
  localparam int FB     = 16;            // fraction bits
  localparam int GW     = DW - 1;        // gain / rate width, unsigned Q
  localparam int TW     = 16;            // tick counter and ramp length width
  localparam int SW     = FB;            // normalized time and its powers
  localparam int PLW    = SW + 11;       // polynomial values p, v, a (signed)
  localparam int AW     = 64;            // multiplicand width (signed)
  localparam int BW     = DW + 2;        // multiplier width (signed)
  localparam int PW     = AW + BW;       // unsigned product width
  localparam int QW     = PW + 1 - FB;   // signed product after the fraction shift
  localparam int ACCW   = DW + 20;       // drive accumulator
  localparam int NREG   = 7;
  localparam int ADDR_W = $clog2(NREG) + 2;
  localparam int RIX_W  = $clog2(NREG);

  // register indexes
  localparam logic [RIX_W-1:0] REG_PROP = RIX_W'(0);
  localparam logic [RIX_W-1:0] REG_DERV = RIX_W'(1);
  localparam logic [RIX_W-1:0] REG_VFF  = RIX_W'(2);
  localparam logic [RIX_W-1:0] REG_AFF  = RIX_W'(3);
  localparam logic [RIX_W-1:0] REG_GOAL = RIX_W'(4);
  localparam logic [RIX_W-1:0] REG_RISE = RIX_W'(5);
  localparam logic [RIX_W-1:0] REG_RATE = RIX_W'(6);

  localparam logic [GW-1:0] RATE_RESET = GW'(64'd1 << FB);
  localparam logic [TW-1:0] RISE_RESET = TW'(1);

  // polynomial coefficients
  localparam logic signed [PLW-1:0] C6   = PLW'(6);
  localparam logic signed [PLW-1:0] C10  = PLW'(10);
  localparam logic signed [PLW-1:0] C15  = PLW'(15);
  localparam logic signed [PLW-1:0] C30  = PLW'(30);
  localparam logic signed [PLW-1:0] C60  = PLW'(60);
  localparam logic signed [PLW-1:0] C120 = PLW'(120);
  localparam logic signed [PLW-1:0] C180 = PLW'(180);

  // multiply sequence
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_S2 = OP_W'(0);
  localparam logic [OP_W-1:0] OP_S3 = OP_W'(1);
  localparam logic [OP_W-1:0] OP_S4 = OP_W'(2);
  localparam logic [OP_W-1:0] OP_S5 = OP_W'(3);
  localparam logic [OP_W-1:0] OP_RP = OP_W'(4);
  localparam logic [OP_W-1:0] OP_GV = OP_W'(5);
  localparam logic [OP_W-1:0] OP_RV = OP_W'(6);
  localparam logic [OP_W-1:0] OP_GA = OP_W'(7);
  localparam logic [OP_W-1:0] OP_AR = OP_W'(8);
  localparam logic [OP_W-1:0] OP_RA = OP_W'(9);
  localparam logic [OP_W-1:0] OP_PG = OP_W'(10);
  localparam logic [OP_W-1:0] OP_DG = OP_W'(11);
  localparam logic [OP_W-1:0] OP_VF = OP_W'(12);
  localparam logic [OP_W-1:0] OP_AF = OP_W'(13);

  localparam logic signed [QW-1:0] QMAX = {{(QW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [QW-1:0] QMIN = {{(QW-DW+1){1'b1}}, {(DW-1){1'b0}}};

  typedef struct packed {
    logic          clip;
    logic [DW-1:0] val;
  } sat_t;

  function automatic sat_t sat_dw(input logic signed [QW-1:0] x);
    sat_t r;
    if (x > QMAX) begin
      r.clip = 1'b1;
      r.val  = QMAX[DW-1:0];
    end else if (x < QMIN) begin
      r.clip = 1'b1;
      r.val  = QMIN[DW-1:0];
    end else begin
      r.clip = 1'b0;
      r.val  = x[DW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### design/mjs_serial_mul.sv
// Bit-serial signed multiplier with floor shift by the fraction bits.
`default_nettype none
module mjs_serial_mul (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire                                     start,
  input  wire logic signed [mjs_pkg::AW-1:0]      a,
  input  wire logic signed [mjs_pkg::BW-1:0]      b,
  output logic                                    done,
  output logic signed [mjs_pkg::QW-1:0]           q
);
  import mjs_pkg::*;

  localparam int CW = $clog2(BW + 1);

  logic                 run;
  logic                 fin;
  logic [CW-1:0]        cnt;
  logic                 neg;
  logic [AW-1:0]        ma;
  logic [AW-1:0]        hi;
  logic [BW-1:0]        lo;
  logic [AW:0]          sum;
  logic [PW-1:0]        prod;
  logic signed [PW:0]   prod_s;
  logic signed [PW:0]   prod_sh;

  always_comb begin
    sum     = {1'b0, hi} + (lo[0] ? {1'b0, ma} : {(AW+1){1'b0}});
    prod    = {hi, lo};
    prod_s  = neg ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
    prod_sh = prod_s >>> FB;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= fin & ~start;
      if (start) begin
        run <= 1'b1;
        cnt <= CW'(BW);
        neg <= a[AW-1] ^ b[BW-1];
        ma  <= a[AW-1] ? AW'(-a) : AW'(a);
        lo  <= b[BW-1] ? BW'(-b) : BW'(b);
        hi  <= '0;
      end else if (run) begin
        // add the multiplicand under the current bit, then shift one place
        hi  <= sum[AW:1];
        lo  <= {sum[0], lo[BW-1:1]};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end else if (fin) begin
        fin  <= 1'b0;
        q    <= prod_sh[QW-1:0];
      end
    end
  end

endmodule
`default_nettype wire

### design/min_jerk_pd_feedforward_servo_unit.sv
// Minimum-jerk trajectory servo: PD feedback plus velocity/acceleration feedforward.
//
// One request on the input channel (meas_position, meas_velocity) is one control
// tick; it yields exactly one result on the output channel. A request is taken
// when in_valid is high and in_stall low; a result leaves when out_valid is high
// and out_stall low. in_stall is high from acceptance until the result is loaded
// into the output register, so one tick is in flight at a time.
// During the ramp a tick runs a restoring divider for the normalized time and then
// 14 products; once the ramp holds it runs 4 products. Each product goes through one
// shared bit-serial multiplier.
// A new request may be accepted while the previous result still waits; a new
// result waits in the last step until the output register is free, so a stalled
// receiver holds the block after one further tick.
// Reset clears the tick counter, channels and registers (ramp length 1, rise rate 1.0).
// Registers are to be written over the APB port only while idle; the block does not
// enforce this. A new value applies from the next tick and does not restart the counter.
`default_nettype none
module min_jerk_pd_feedforward_servo_unit (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire                                     psel,
  input  wire                                     penable,
  input  wire                                     pwrite,
  input  wire logic [mjs_pkg::ADDR_W-1:0]         paddr,
  input  wire logic [31:0]                        pwdata,
  output logic [31:0]                             prdata,
  output logic                                    pready,
  input  wire                                     in_valid,
  output logic                                    in_stall,
  input  wire logic signed [mjs_pkg::DW-1:0]      meas_position,
  input  wire logic signed [mjs_pkg::DW-1:0]      meas_velocity,
  output logic                                    out_valid,
  input  wire                                     out_stall,
  output logic signed [mjs_pkg::DW-1:0]           drive,
  output logic                                    drive_saturated,
  output logic signed [mjs_pkg::DW-1:0]           ref_position,
  output logic signed [mjs_pkg::DW-1:0]           ref_velocity,
  output logic signed [mjs_pkg::DW-1:0]           ref_accel,
  output logic                                    ramp_done
);
  import mjs_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_MUL  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;
  localparam int DCW = $clog2(SW + 1);

  // configuration
  logic [GW-1:0]        prop_gain, deriv_gain, vel_ff_gain, acc_ff_gain, rise_rate;
  logic signed [DW-1:0] goal_position;
  logic [TW-1:0]        rise_ticks;
  logic                 cfg_wr;
  logic [RIX_W-1:0]     cfg_ix;

  // datapath
  logic [1:0]             state;
  logic [TW-1:0]          tick_count;
  logic [DCW-1:0]         div_cnt;
  logic [TW-1:0]          rem;
  logic [TW:0]            rem_sh;
  logic [SW-1:0]          s1, s2, s3, s4, s5;
  logic signed [PLW-1:0]  z1, z2, z3, z4, z5, pl_p, pl_v, pl_a;
  logic signed [DW-1:0]   mp, mv, rp, rv, ra;
  logic signed [AW-1:0]   t;
  logic signed [ACCW-1:0] acc;
  logic signed [ACCW-1:0] term;
  logic                   ramp;
  logic [OP_W-1:0]        op;
  logic                   mul_start, mul_done;
  logic                   mul_start_next;
  logic signed [AW-1:0]   mul_a;
  logic signed [BW-1:0]   mul_b;
  logic signed [QW-1:0]   mul_q;
  sat_t                   q_sat, acc_sat;
  logic                   in_acc;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_ix  = paddr[ADDR_W-1:2];
  assign in_stall = (state != ST_IDLE);
  assign in_acc  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain     <= '0;
      deriv_gain    <= '0;
      vel_ff_gain   <= '0;
      acc_ff_gain   <= '0;
      goal_position <= '0;
      rise_ticks    <= RISE_RESET;
      rise_rate     <= RATE_RESET;
    end else if (cfg_wr) begin
      case (cfg_ix)
        REG_PROP: prop_gain     <= pwdata[GW-1:0];
        REG_DERV: deriv_gain    <= pwdata[GW-1:0];
        REG_VFF:  vel_ff_gain   <= pwdata[GW-1:0];
        REG_AFF:  acc_ff_gain   <= pwdata[GW-1:0];
        REG_GOAL: goal_position <= pwdata[DW-1:0];
        REG_RISE: rise_ticks    <= pwdata[TW-1:0];
        REG_RATE: rise_rate     <= pwdata[GW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_ix)
      REG_PROP: prdata = {1'b0, prop_gain};
      REG_DERV: prdata = {1'b0, deriv_gain};
      REG_VFF:  prdata = {1'b0, vel_ff_gain};
      REG_AFF:  prdata = {1'b0, acc_ff_gain};
      REG_GOAL: prdata = goal_position;
      REG_RISE: prdata = {16'd0, rise_ticks};
      REG_RATE: prdata = {1'b0, rise_rate};
      default:  prdata = '0;
    endcase
  end

  // polynomial in the normalized time
  always_comb begin
    z1   = {{(PLW-SW){1'b0}}, s1};
    z2   = {{(PLW-SW){1'b0}}, s2};
    z3   = {{(PLW-SW){1'b0}}, s3};
    z4   = {{(PLW-SW){1'b0}}, s4};
    z5   = {{(PLW-SW){1'b0}}, s5};
    pl_p = C10 * z3 - C15 * z4 + C6 * z5;
    pl_v = C30 * z2 - C60 * z3 + C30 * z4;
    pl_a = C60 * z1 - C180 * z2 + C120 * z3;
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_S2: begin mul_a = AW'(s1); mul_b = BW'(s1); end
      OP_S3: begin mul_a = AW'(s2); mul_b = BW'(s1); end
      OP_S4: begin mul_a = AW'(s3); mul_b = BW'(s1); end
      OP_S5: begin mul_a = AW'(s4); mul_b = BW'(s1); end
      OP_RP: begin mul_a = AW'(goal_position); mul_b = BW'(pl_p); end
      OP_GV: begin mul_a = AW'(goal_position); mul_b = BW'(pl_v); end
      OP_GA: begin mul_a = AW'(goal_position); mul_b = BW'(pl_a); end
      OP_RV, OP_AR, OP_RA: begin
        mul_a = t;
        mul_b = $signed({{(BW-GW){1'b0}}, rise_rate});
      end
      OP_PG: begin
        mul_a = AW'(rp) - AW'(mp);
        mul_b = $signed({{(BW-GW){1'b0}}, prop_gain});
      end
      OP_DG: begin mul_a = AW'(mv); mul_b = $signed({{(BW-GW){1'b0}}, deriv_gain}); end
      OP_VF: begin mul_a = AW'(rv); mul_b = $signed({{(BW-GW){1'b0}}, vel_ff_gain}); end
      OP_AF: begin mul_a = AW'(ra); mul_b = $signed({{(BW-GW){1'b0}}, acc_ff_gain}); end
      default: ;
    endcase
  end

  mjs_serial_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .q     (mul_q)
  );

  always_comb begin
    rem_sh  = {rem, 1'b0};
    q_sat   = sat_dw(mul_q);
    term    = mul_q[ACCW-1:0];
    acc_sat = sat_dw({{(QW-ACCW){acc[ACCW-1]}}, acc});
  end

  // launch a product on entry to the hold path, after the divider, and between products
  always_comb begin
    case (state)
      ST_IDLE: mul_start_next = in_acc && (tick_count >= rise_ticks);
      ST_DIV:  mul_start_next = (div_cnt == DCW'(1));
      ST_MUL:  mul_start_next = mul_done && (op != OP_AF);
      default: mul_start_next = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      tick_count <= '0;
      mul_start  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      mul_start <= mul_start_next;
      if (out_valid && !out_stall && state != ST_FIN) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc) begin
            mp   <= meas_position;
            mv   <= meas_velocity;
            rem  <= tick_count;
            s1   <= '0;
            ramp <= (tick_count >= rise_ticks);
            if (tick_count != '1) begin
              tick_count <= tick_count + TW'(1);
            end
            if (tick_count >= rise_ticks) begin
              // hold at goal: skip the trajectory products
              rp        <= goal_position;
              rv        <= '0;
              ra        <= '0;
              op        <= OP_PG;
              state     <= ST_MUL;
            end else begin
              div_cnt <= DCW'(SW);
              state   <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          // one quotient bit per cycle; tick < ramp length keeps it below 1.0
          if (rem_sh >= {1'b0, rise_ticks}) begin
            rem <= TW'(rem_sh - {1'b0, rise_ticks});
            s1  <= {s1[SW-2:0], 1'b1};
          end else begin
            rem <= rem_sh[TW-1:0];
            s1  <= {s1[SW-2:0], 1'b0};
          end
          div_cnt <= div_cnt - DCW'(1);
          if (div_cnt == DCW'(1)) begin
            op        <= OP_S2;
            state     <= ST_MUL;
          end
        end
        ST_MUL: begin
          if (mul_done) begin
            case (op)
              OP_S2: s2 <= mul_q[SW-1:0];
              OP_S3: s3 <= mul_q[SW-1:0];
              OP_S4: s4 <= mul_q[SW-1:0];
              OP_S5: s5 <= mul_q[SW-1:0];
              OP_RP: rp <= q_sat.val;
              OP_GV, OP_GA, OP_AR: t <= mul_q[AW-1:0];
              OP_RV: rv <= q_sat.val;
              OP_RA: ra <= q_sat.val;
              OP_PG: acc <= term;
              OP_DG: acc <= acc - term;
              OP_VF, OP_AF: acc <= acc + term;
              default: ;
            endcase
            if (op == OP_AF) begin
              state <= ST_FIN;
            end else begin
              op        <= op + OP_W'(1);
            end
          end
        end
        ST_FIN: begin
          // hold until the output register is free
          if (!out_valid || !out_stall) begin
            drive           <= acc_sat.val;
            drive_saturated <= acc_sat.clip;
            ref_position    <= rp;
            ref_velocity    <= rv;
            ref_accel       <= ra;
            ramp_done       <= ramp;
            out_valid       <= 1'b1;
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

### design/mjs_checker.sv
// Port-level checks for the minimum-jerk servo, bound to the top level.
`default_nettype none
module mjs_checker (
  input wire                        clk,
  input wire                        rst,
  input wire                        out_valid,
  input wire                        out_stall,
  input wire logic [31:0]           drive,
  input wire                        drive_saturated,
  input wire logic [31:0]           ref_velocity,
  input wire logic [31:0]           ref_accel,
  input wire                        ramp_done
);

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_hold_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(drive))
    else $error("stalled drive changed");

  a_clip_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && drive_saturated |-> (drive == 32'h7fffffff || drive == 32'h80000000))
    else $error("saturation flag without rail value");

  a_hold_refs: assert property (@(posedge clk) disable iff (rst)
    out_valid && ramp_done |-> (ref_velocity == 32'd0 && ref_accel == 32'd0))
    else $error("nonzero velocity or acceleration after ramp");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

endmodule

bind min_jerk_pd_feedforward_servo_unit mjs_checker u_mjs_checker (.*);
`default_nettype wire

### tb/mjs_servo_checker.sv
// Checker for the minimum-jerk servo: tracks registers, predicts each tick, compares results.
`timescale 1ns / 1ps
module mjs_servo_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [mjs_pkg::ADDR_W-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic signed [mjs_pkg::DW-1:0]  meas_position,
  input  logic signed [mjs_pkg::DW-1:0]  meas_velocity,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic signed [mjs_pkg::DW-1:0]  drive,
  input  logic                           drive_saturated,
  input  logic signed [mjs_pkg::DW-1:0]  ref_position,
  input  logic signed [mjs_pkg::DW-1:0]  ref_velocity,
  input  logic signed [mjs_pkg::DW-1:0]  ref_accel,
  input  logic                           ramp_done,
  output int                             errors
);
  import mjs_pkg::*;

  typedef struct packed {
    logic signed [DW-1:0] drv;
    logic                 sat;
    logic signed [DW-1:0] pos;
    logic signed [DW-1:0] vel;
    logic signed [DW-1:0] acc;
    logic                 done;
  } servo_out_t;

  localparam logic signed [63:0] TERM_CAP = 64'sd1 <<< 60;

  logic [GW-1:0]        kp, kd, kv, ka, rate;
  logic signed [DW-1:0] goal;
  logic [TW-1:0]        rise, tick;
  servo_out_t           expected_q[$];

  // floor(a*b / 2^FB), clamped to the term cap
  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [127:0] x, y, pr;
    x = a;
    y = b;
    pr = (x * y) >>> FB;
    if (pr > TERM_CAP) return TERM_CAP;
    if (pr < -TERM_CAP) return -TERM_CAP;
    return pr[63:0];
  endfunction

  function automatic logic signed [DW-1:0] clamp_dw(input logic signed [63:0] x,
                                                     output logic clip);
    clip = 1'b1;
    if (x > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
    if (x < -64'sh8000_0000) return 32'sh8000_0000;
    clip = 1'b0;
    return x[DW-1:0];
  endfunction

  function automatic servo_out_t servo_tick(input logic signed [DW-1:0] mp,
                                            input logic signed [DW-1:0] mv);
    servo_out_t r;
    logic signed [63:0] g, rr, s, s2, s3, s4, s5, p, v, a, rp, rv, ra, u;
    logic               dummy, clip;
    g = goal;
    rr = {33'b0, rate};
    r.done = tick >= rise;
    if (r.done) begin
      rp = g;
      rv = 0;
      ra = 0;
    end else begin
      s  = {32'b0, tick, 16'b0} / {48'b0, rise};
      s2 = (s * s) >>> FB;
      s3 = (s2 * s) >>> FB;
      s4 = (s3 * s) >>> FB;
      s5 = (s4 * s) >>> FB;
      p  = 10 * s3 - 15 * s4 + 6 * s5;
      v  = 30 * s2 - 60 * s3 + 30 * s4;
      a  = 60 * s - 180 * s2 + 120 * s3;
      rp = clamp_dw(qmul(g, p), dummy);
      rv = clamp_dw(qmul(qmul(g, v), rr), dummy);
      ra = clamp_dw(qmul(qmul(qmul(g, a), rr), rr), dummy);
    end
    u = qmul({33'b0, kp}, rp - 64'(mp)) - qmul({33'b0, kd}, 64'(mv))
      + qmul({33'b0, kv}, rv) + qmul({33'b0, ka}, ra);
    r.drv = clamp_dw(u, clip);
    r.sat = clip;
    r.pos = rp[DW-1:0];
    r.vel = rv[DW-1:0];
    r.acc = ra[DW-1:0];
    if (tick != 16'hFFFF) tick = tick + 1'b1;
    return r;
  endfunction

  task automatic cmp(input string name, input logic [63:0] e, input logic [63:0] a);
    if (e !== a) begin
      errors++;
      $display("%0t mismatch %s: expected %0h actual %0h", $time, name, e, a);
    end
  endtask

  always @(posedge clk) begin
    servo_out_t e;
    if (rst) begin
      kp = '0; kd = '0; kv = '0; ka = '0; goal = '0;
      rise = RISE_RESET; rate = RATE_RESET; tick = '0;
      expected_q.delete();
      errors = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_PROP: kp = pwdata[GW-1:0];
          REG_DERV: kd = pwdata[GW-1:0];
          REG_VFF:  kv = pwdata[GW-1:0];
          REG_AFF:  ka = pwdata[GW-1:0];
          REG_GOAL: goal = pwdata;
          REG_RISE: rise = pwdata[TW-1:0];
          REG_RATE: rate = pwdata[GW-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t unexpected result: drive %0h", $time, drive);
        end else begin
          e = expected_q.pop_front();
          cmp("drive", e.drv, drive);
          cmp("drive_saturated", e.sat, drive_saturated);
          cmp("ref_position", e.pos, ref_position);
          cmp("ref_velocity", e.vel, ref_velocity);
          cmp("ref_accel", e.acc, ref_accel);
          cmp("ramp_done", e.done, ramp_done);
        end
      end
      if (in_valid && !in_stall) expected_q.push_back(servo_tick(meas_position, meas_velocity));
    end
  end

endmodule

### tb/tb.sv
// Testbench top for the minimum-jerk servo: stimulus, register setup and verdict.
`timescale 1ns / 1ps
module tb;
  import mjs_pkg::*;

  localparam logic [RIX_W-1:0] REG_NONE = RIX_W'(7);
  localparam int IDLE_PCT = 31;
  localparam int WATCHDOG = 40000;
  localparam logic [31:0] GMAX = 32'h7FFF_FFFF;

  logic clk = 1'b0, rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  logic in_valid = 1'b0, in_stall, out_valid, out_stall = 1'b0;
  logic signed [DW-1:0] meas_position = '0, meas_velocity = '0;
  logic signed [DW-1:0] drive, ref_position, ref_velocity, ref_accel;
  logic drive_saturated, ramp_done;
  int errors, sent = 0, received = 0, quiet = 0;
  bit steady = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  min_jerk_pd_feedforward_servo_unit u_dut (.*);

  mjs_servo_checker u_chk (.*);

  always @(posedge clk) begin
    if (out_valid && !out_stall) received++;
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
    else quiet++;
    if (quiet >= WATCHDOG) begin
      $display("== FAIL ==");
      $finish;
    end
    out_stall <= !steady && ($urandom_range(99) < IDLE_PCT);
  end

  task automatic reg_write(input logic [RIX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // drop the request, then hold until every request has its result
  task automatic drain();
    in_valid <= 1'b0;
    while (received != sent) @(posedge clk);
  endtask

  task automatic setup(input logic [31:0] kp, kd, kv, ka, goal, rise, rate);
    drain();
    reg_write(REG_PROP, kp);
    reg_write(REG_DERV, kd);
    reg_write(REG_VFF, kv);
    reg_write(REG_AFF, ka);
    reg_write(REG_GOAL, goal);
    reg_write(REG_RISE, rise);
    reg_write(REG_RATE, rate);
  endtask

  task automatic send(input logic [31:0] mp, input logic [31:0] mv);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    meas_position <= mp;
    meas_velocity <= mv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  function automatic logic [31:0] rand_gain();
    case ($urandom_range(4))
      0: return 0;
      1: return GMAX;
      2: return $urandom_range(32'h3_0000);
      default: return $urandom() >> 1;
    endcase
  endfunction

  function automatic logic [31:0] rand_meas();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(32'h4_0000) - 32'h2_0000;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [31:0] rise;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    // reset settings: zero goal and gains, ramp of one tick
    send(32'h0001_0000, 32'hFFFF_0000);
    send(32'h8000_0000, 32'h7FFF_FFFF);
    // short ramp, moderate gains
    setup(32'h0002_0000, 32'h0000_8000, 32'h0001_0000, 32'h0000_4000,
          32'h0003_0000, 32'd8, 32'h0002_0000);
    reg_write(REG_NONE, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) send(32'h0000_1000 * i, 32'hFFFF_F000);
    // extremes: full gains, most negative goal, long ramp, large rate
    setup(GMAX, GMAX, GMAX, GMAX, 32'h8000_0000, 32'hFFFF, GMAX);
    send(32'h7FFF_FFFF, 32'h8000_0000);
    send(32'h8000_0000, 32'h7FFF_FFFF);
    send(32'h0, 32'h0);
    // zero rise rate and zero ramp length
    setup(32'h0001_0000, 0, GMAX, GMAX, 32'h7FFF_FFFF, 32'd20000, 0);
    send(32'h1234_5678, 32'h8765_4321);
    setup(32'h0001_0000, 32'h0001_0000, 0, 0, 32'h7FFF_FFFF, 0, 32'h1);
    send(32'hFFFF_FFFF, 32'h0000_0001);
    send(32'h8000_0000, 32'h8000_0000);
    // random phases, each with fresh registers
    for (int ph = 0; ph < 19; ph++) begin
      steady = (ph == 7);
      case ($urandom_range(3))
        0: rise = $urandom_range(1, 40);
        1: rise = sent + $urandom_range(50, 400);
        2: rise = $urandom_range(65535);
        default: rise = $urandom_range(2);
      endcase
      setup(rand_gain(), rand_gain(), rand_gain(), rand_gain(),
            ($urandom_range(1) ? $urandom() : $urandom_range(32'h8_0000) - 32'h4_0000),
            rise, ($urandom_range(5) == 0) ? 0 : $urandom_range(1, 32'h8_0000));
      for (int i = 0; i < 100; i++) send(rand_meas(), rand_meas());
    end
    steady = 1'b0;
    drain();
    repeat (600) @(posedge clk);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
